// ----- sv/fgpd_pkg.sv -----
// ----------------------------------------------------------------------------
// fgpd_pkg
// Shared types and constants of the fuzzy gain-scheduled PD controller.
// ----------------------------------------------------------------------------
package fgpd_pkg;

  localparam int unsigned ValW  = 12;
  localparam int unsigned GainW = 20;
  localparam int unsigned SpW   = 8;
  localparam int unsigned DrvW  = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegErrSp  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegChgSp  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPMin   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPMax   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDMax   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPStart = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDStart = 3'd7;

  localparam int RuleN = 7;

  typedef struct packed {
    logic signed [ValW-1:0] error_value;
    logic signed [ValW-1:0] error_change;
  } in_item_t;

  typedef struct packed {
    logic signed [DrvW-1:0]  drive;
    logic        [GainW-1:0] p_gain_now;
    logic        [GainW-1:0] d_gain_now;
  } out_item_t;

  // Rule offsets; indices outside the table give zero.
  function automatic logic signed [2:0] kp_rule(input int i, input int j);
    logic signed [2:0] t [0:6][0:6];
    t = '{'{3,3,2,2,1,0,0}, '{3,3,2,1,1,0,-1}, '{2,2,2,1,0,-1,-1},
          '{2,2,1,0,-1,-2,-2}, '{1,1,0,-1,-1,-2,-2}, '{1,0,-1,-2,-2,-2,-3},
          '{0,0,-2,-2,-2,-3,-3}};
    if (i < 0 || j < 0 || i >= RuleN || j >= RuleN) return 3'sd0;
    return t[i][j];
  endfunction

  function automatic logic signed [2:0] kd_rule(input int i, input int j);
    logic signed [2:0] t [0:6][0:6];
    t = '{'{1,-1,-3,-3,-3,-2,1}, '{1,-1,-3,-2,-2,-1,0}, '{0,-1,-2,-2,-1,-1,0},
          '{0,-1,-1,-1,-1,-1,0}, '{0,0,0,0,0,0,0}, '{3,-1,1,1,1,1,3},
          '{3,2,2,2,1,1,3}};
    if (i < 0 || j < 0 || i >= RuleN || j >= RuleN) return 3'sd0;
    return t[i][j];
  endfunction

endpackage

// ----- sv/fgpd_if.sv -----
// ----------------------------------------------------------------------------
// fgpd_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface fgpd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/fgpd_front.sv -----
// ----------------------------------------------------------------------------
// fgpd_front
// Accepts items and fuzzifies error and change by a shared serial divider,
// then pushes the level indices and weights into a short queue.
// ----------------------------------------------------------------------------
module fgpd_front #(
  parameter int Levels   = 7,
  parameter int FracBits = 16,
  parameter int IdxW     = 4,
  parameter int WW       = 17
) (
  input  logic clk_i,
  input  logic rst_ni,
  fgpd_if.sink in_if,
  input  logic [fgpd_pkg::SpW-1:0] err_sp_i,
  input  logic [fgpd_pkg::SpW-1:0] chg_sp_i,
  output logic            push_o,
  output logic [2*fgpd_pkg::ValW+2*IdxW+2*WW+2-1:0] push_data_o,
  input  logic            full_i
);
  import fgpd_pkg::*;

  localparam int Half = (Levels - 1) / 2;
  localparam int DW   = ValW + 6;            // span up to 3*255 + 2047
  localparam int QW   = DW + FracBits;       // numerator width
  localparam int CntW = $clog2(QW + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0] st_q, st_d;
  logic       which_q;                // 0: error, 1: change
  in_item_t   item_q;
  logic [QW-1:0] num_q;
  logic [DW+SpW:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] ie_q, ic_q;
  logic [WW-1:0]   we_q, wc_q;         // weight of the lower level
  logic            te_q, tc_q;         // two levels in use
  logic [QW-1:0]   quo_q;

  logic [SpW-1:0] sp;
  logic signed [ValW-1:0] x;
  logic signed [DW-1:0] lo, hi, dx;
  logic [DW+SpW:0] rem_sh;
  logic [QW-1:0]   quo_n;
  logic [DW+SpW:0] rem_n;
  logic [DW-1:0]   iq;
  logic [WW-1:0]   up;

  assign sp = which_q ? (chg_sp_i == '0 ? SpW'(1) : chg_sp_i)
                      : (err_sp_i == '0 ? SpW'(1) : err_sp_i);
  assign x  = which_q ? item_q.error_change : item_q.error_value;
  assign lo = -$signed(DW'(Half)) * $signed(DW'(sp));
  assign hi = $signed(DW'(Levels - 1 - Half)) * $signed(DW'(sp));
  assign dx = DW'(x) - lo;

  // Restoring division of (d << F) by spacing; the integer part i = d / sp
  // comes from the same pass as the top DW quotient bits.
  assign rem_sh = {rem_q[DW+SpW-1:0], num_q[QW-1]};
  always_comb begin
    if (rem_sh >= (DW+SpW+1)'(sp)) begin
      rem_n = rem_sh - (DW+SpW+1)'(sp);
      quo_n = {quo_q[QW-2:0], 1'b1};
    end else begin
      rem_n = rem_sh;
      quo_n = {quo_q[QW-2:0], 1'b0};
    end
  end
  // After the full pass quo holds floor(d * 2^F / sp): integer part on top,
  // fractional weight below; this equals floor(r * 2^F / sp) exactly.
  assign iq = quo_q[QW-1:FracBits];
  assign up = WW'(quo_q[FracBits-1:0]);

  assign in_if.ready = (st_q == StIdle);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_if.valid) st_d = StDiv;
      StDiv:  if (cnt_q == '0 && which_q) st_d = StPush;
      StPush: if (!full_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      which_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StIdle && in_if.valid) begin
        which_q <= 1'b0;
        cnt_q   <= CntW'(QW + 1);
      end else if (st_q == StDiv) begin
        if (cnt_q == '0) begin
          which_q <= 1'b1;
          cnt_q   <= CntW'(QW + 1);
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Payload path: the first count step loads the numerator, the last one classifies.
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_if.valid) item_q <= in_if.data;
    if (st_q == StDiv) begin
      if (cnt_q == CntW'(QW + 1)) begin
        num_q <= {dx, {FracBits{1'b0}}};
        rem_q <= '0;
        quo_q <= '0;
      end else if (cnt_q != '0) begin
        num_q <= {num_q[QW-2:0], 1'b0};
        rem_q <= rem_n;
        quo_q <= quo_n;
      end else begin
        if ($signed(DW'(x)) <= lo) begin
          if (!which_q) begin ie_q <= '0; we_q <= WW'(1) << FracBits; te_q <= 1'b0; end
          else          begin ic_q <= '0; wc_q <= WW'(1) << FracBits; tc_q <= 1'b0; end
        end else if ($signed(DW'(x)) >= hi) begin
          if (!which_q) begin
            ie_q <= IdxW'(Levels - 1); we_q <= WW'(1) << FracBits; te_q <= 1'b0;
          end else begin
            ic_q <= IdxW'(Levels - 1); wc_q <= WW'(1) << FracBits; tc_q <= 1'b0;
          end
        end else begin
          if (!which_q) begin
            ie_q <= IdxW'(iq); we_q <= (WW'(1) << FracBits) - up; te_q <= 1'b1;
          end else begin
            ic_q <= IdxW'(iq); wc_q <= (WW'(1) << FracBits) - up; tc_q <= 1'b1;
          end
        end
      end
    end
  end

  assign push_o = (st_q == StPush) && !full_i;
  assign push_data_o = {item_q.error_value, item_q.error_change, ie_q, ic_q,
                        we_q, wc_q, te_q, tc_q};

endmodule

// ----- sv/fgpd_queue.sv -----
// ----------------------------------------------------------------------------
// fgpd_queue
// Two-entry queue between the fuzzifier and the rule engine.
// ----------------------------------------------------------------------------
module fgpd_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] pop_data_o
);
  logic [W-1:0] mem_q [0:1];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end
endmodule

// ----- sv/fgpd_back.sv -----
// ----------------------------------------------------------------------------
// fgpd_back
// Accumulates rule products, updates and clamps the gains, forms the drive.
// ----------------------------------------------------------------------------
module fgpd_back #(
  parameter int FracBits = 16,
  parameter int IdxW     = 4,
  parameter int WW       = 17
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  logic [2*fgpd_pkg::ValW+2*IdxW+2*WW+2-1:0] pop_data_i,
  output logic pop_o,
  input  logic [fgpd_pkg::GainW-1:0] p_min_i, p_max_i, d_min_i, d_max_i,
  input  logic [fgpd_pkg::GainW-1:0] p_start_i, d_start_i,
  input  logic start_ld_i,
  fgpd_if.source out_if
);
  import fgpd_pkg::*;

  localparam int Step = ((1 << FracBits) * 4 + 50) / 100;
  localparam int AW   = WW + 5;          // sum of 4 products times |3|
  localparam int SW   = AW + 16;
  localparam int TW   = ValW + GainW + 2;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StProd = 4'd1;
  localparam logic [3:0] StAcc  = 4'd2;
  localparam logic [3:0] StScl  = 4'd3;
  localparam logic [3:0] StUpd  = 4'd4;
  localparam logic [3:0] StMulE = 4'd5;
  localparam logic [3:0] StMulC = 4'd6;
  localparam logic [3:0] StDrv  = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;

  logic signed [ValW-1:0] e, c;
  logic [IdxW-1:0] ie, ic;
  logic [WW-1:0] we, wc;
  logic te, tc;
  assign {e, c, ie, ic, we, wc, te, tc} = pop_data_i;

  logic [3:0] st_q;
  logic [1:0] k_q;
  logic [WW-1:0] prod_q;
  logic signed [AW-1:0] accp_q, accd_q;
  logic signed [SW-1:0] sp_q, sd_q;
  logic [GainW-1:0] kp_q, kd_q;
  logic signed [TW-1:0] t_q, te_q;
  out_item_t res_q;
  logic out_v_q;

  logic ki, kj;
  logic kval;
  logic [2*WW-1:0] mul;
  logic signed [3:0] rp, rd;
  logic signed [SW-FracBits-1:0] incp, incd;
  logic signed [GainW+2:0] gp, gd;
  logic signed [TW-1:0] drv;

  assign ki   = k_q[1];
  assign kj   = k_q[0];
  assign kval = (!ki || te) && (!kj || tc);
  assign mul  = (ki ? ((WW'(1) << FracBits) - we) : we)
              * (kj ? ((WW'(1) << FracBits) - wc) : wc);
  assign rp = 4'(kp_rule(int'(ie) + int'(ki), int'(ic) + int'(kj)));
  assign rd = 4'(kd_rule(int'(ie) + int'(ki), int'(ic) + int'(kj)));
  // Dropping the fraction bits of a signed value floors it.
  assign incp = sp_q[SW-1:FracBits];
  assign incd = sd_q[SW-1:FracBits];

  function automatic logic [GainW-1:0] clampg(input logic signed [GainW+2:0] g,
                                              input logic [GainW-1:0] mn,
                                              input logic [GainW-1:0] mx);
    logic signed [GainW+2:0] v;
    v = g;
    if (v < $signed({3'b0, mn})) v = $signed({3'b0, mn});
    if (v > $signed({3'b0, mx})) v = $signed({3'b0, mx});
    return v[GainW-1:0];
  endfunction

  assign gp = $signed({3'b0, kp_q}) + (GainW+3)'(incp);
  assign gd = $signed({3'b0, kd_q}) + (GainW+3)'(incd);
  assign drv = t_q < 0 ? -((-t_q) >>> FracBits) : (t_q >>> FracBits);

  assign pop_o        = (st_q == StOut) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; k_q <= '0; out_v_q <= 1'b0;
      kp_q <= 20'd78643; kd_q <= 20'd65536;
    end else begin
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      if (start_ld_i) begin kp_q <= p_start_i; kd_q <= d_start_i; end
      case (st_q)
        StIdle: if (!empty_i) begin st_q <= StProd; k_q <= '0; end
        StProd: st_q <= StAcc;
        StAcc: begin
          k_q  <= k_q + 1'b1;
          st_q <= (k_q == 2'd3) ? StScl : StProd;
        end
        StScl: st_q <= StUpd;
        StUpd: begin
          kp_q <= clampg(gp, p_min_i, p_max_i);
          kd_q <= clampg(gd, d_min_i, d_max_i);
          st_q <= StMulE;
        end
        StMulE: st_q <= StMulC;
        StMulC: st_q <= StDrv;
        StDrv:  st_q <= StOut;
        StOut: if (!out_v_q) begin out_v_q <= 1'b1; st_q <= StIdle; end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin accp_q <= '0; accd_q <= '0; end
      StProd: prod_q <= kval ? WW'(mul >> FracBits) : '0;
      StAcc: begin
        accp_q <= accp_q + AW'(rp) * $signed({1'b0, prod_q});
        accd_q <= accd_q + AW'(rd) * $signed({1'b0, prod_q});
      end
      StScl: begin
        sp_q <= SW'(accp_q) * $signed(SW'(Step));
        sd_q <= SW'(accd_q) * $signed(SW'(Step));
      end
      StMulE: te_q <= TW'(e) * $signed({1'b0, kp_q});
      StMulC: t_q  <= te_q + TW'(c) * $signed({1'b0, kd_q});
      // The result register is only loaded once the previous result has left.
      StOut: if (!out_v_q) begin
        res_q.drive <= (drv > 24576) ? 16'sd24576 :
                       (drv < -24576) ? -16'sd24576 : DrvW'(drv);
        res_q.p_gain_now <= kp_q;
        res_q.d_gain_now <= kd_q;
      end
      default: ;
    endcase
  end
endmodule

// ----- sv/fuzzy_gain_scheduled_pd.sv -----
// ----------------------------------------------------------------------------
// fuzzy_gain_scheduled_pd
// Fuzzy self-tuning PD controller with 7x7 rule tables for kp and kd.
// ----------------------------------------------------------------------------
// The front fuzzifies error then change with one bit-serial divider; the back
// forms four rule products, updates the gains and does two drive multiplies.
// The front takes a new item only after it has pushed the last one into the
// queue; the queue lets the back overlap the next item.
// Reset clears all control state and loads registers and gains with defaults.
// ----------------------------------------------------------------------------
module fuzzy_gain_scheduled_pd #(
  parameter int Levels   = 7,
  parameter int FracBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  fgpd_if.sink   in_if,
  fgpd_if.source out_if,
  input  logic                          cfg_we_i,
  input  logic [fgpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fgpd_pkg::GainW-1:0]    cfg_data_i
);
  import fgpd_pkg::*;

  localparam int IdxW = $clog2(Levels + 1);
  localparam int WW   = FracBits + 1;
  localparam int QDW  = 2*ValW + 2*IdxW + 2*WW + 2;

  // Configuration registers.
  logic [SpW-1:0]   err_sp_q, chg_sp_q;
  logic [GainW-1:0] p_min_q, p_max_q, d_min_q, d_max_q, p_st_q, d_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sp_q <= 8'd30;  chg_sp_q <= 8'd4;
      p_min_q  <= 20'd65536; p_max_q <= 20'd131072;
      d_min_q  <= 20'd65536; d_max_q <= 20'd655360;
      p_st_q   <= 20'd78643; d_st_q  <= 20'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegErrSp:  err_sp_q <= cfg_data_i[SpW-1:0];
        RegChgSp:  chg_sp_q <= cfg_data_i[SpW-1:0];
        RegPMin:   p_min_q  <= cfg_data_i;
        RegPMax:   p_max_q  <= cfg_data_i;
        RegDMin:   d_min_q  <= cfg_data_i;
        RegDMax:   d_max_q  <= cfg_data_i;
        RegPStart: p_st_q   <= cfg_data_i;
        RegDStart: d_st_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic push, full, pop, empty;
  logic [QDW-1:0] push_data, pop_data;

  fgpd_front #(.Levels(Levels), .FracBits(FracBits), .IdxW(IdxW), .WW(WW)) u_front (
    .clk_i, .rst_ni, .in_if,
    .err_sp_i(err_sp_q), .chg_sp_i(chg_sp_q),
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  fgpd_queue #(.W(QDW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  // The start-gain load is tied off, so the start gains are never loaded; they are kept as registers.
  fgpd_back #(.FracBits(FracBits), .IdxW(IdxW), .WW(WW)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .pop_data_i(pop_data), .pop_o(pop),
    .p_min_i(p_min_q), .p_max_i(p_max_q), .d_min_i(d_min_q), .d_max_i(d_max_q),
    .p_start_i(p_st_q), .d_start_i(d_st_q), .start_ld_i(1'b0), .out_if
  );
endmodule

// ----- dv/fgpd_checker.sv -----
// ----------------------------------------------------------------------------
// fgpd_checker
// Watches the input, output and register ports of the fuzzy gain-scheduled
// PD controller, predicts each result from its own copy of the gains and
// registers, and compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fgpd_checker
  import fgpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  fgpd_if                     in_mon,
  fgpd_if                     out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [GainW-1:0]    cfg_data_i,
  output int                  fails_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam longint One      = 64'sd1 << 16;
  localparam longint LevelStep = (One * 4 + 50) / 100;
  localparam longint DriveLim = 24576;

  logic [SpW-1:0]   err_sp, chg_sp;
  logic [GainW-1:0] p_min, p_max, d_min, d_max, p_start, d_start;
  logic [GainW-1:0] kp_now, kd_now;
  out_item_t        expected_q[$];
  int               in_cnt, out_cnt;

  assign pending_o = in_cnt - out_cnt;
  assign checked_o = out_cnt;

  // Two adjacent levels with linear weights, or one end level at full weight.
  function automatic void fuzz(input longint x, input logic [SpW-1:0] sp_reg,
                               output int idx[2], output longint w[2], output int n);
    longint sp, lo, hi, d, i, r, up;
    sp = (sp_reg == 0) ? 1 : longint'(sp_reg);
    lo = -3 * sp;
    hi = 3 * sp;
    idx[1] = 0;
    w[1]   = 0;
    if (x <= lo) begin
      n = 1; idx[0] = 0; w[0] = One;
    end else if (x >= hi) begin
      n = 1; idx[0] = 6; w[0] = One;
    end else begin
      d = x - lo;
      i = d / sp;
      r = d - i * sp;
      up = (r * One) / sp;
      n = 2;
      idx[0] = int'(i);
      idx[1] = int'(i) + 1;
      w[0] = One - up;
      w[1] = up;
    end
  endfunction

  function automatic logic [GainW-1:0] clamp(input longint g, input logic [GainW-1:0] mn,
                                            input logic [GainW-1:0] mx);
    if (g < longint'(mn)) g = longint'(mn);
    if (g > longint'(mx)) g = longint'(mx);
    return g[GainW-1:0];
  endfunction

  function automatic int rule_of(input bit for_kd, input int i, input int j);
    int kp_t [7][7];
    int kd_t [7][7];
    kp_t = '{'{3,3,2,2,1,0,0}, '{3,3,2,1,1,0,-1}, '{2,2,2,1,0,-1,-1},
             '{2,2,1,0,-1,-2,-2}, '{1,1,0,-1,-1,-2,-2}, '{1,0,-1,-2,-2,-2,-3},
             '{0,0,-2,-2,-2,-3,-3}};
    kd_t = '{'{1,-1,-3,-3,-3,-2,1}, '{1,-1,-3,-2,-2,-1,0}, '{0,-1,-2,-2,-1,-1,0},
             '{0,-1,-1,-1,-1,-1,0}, '{0,0,0,0,0,0,0}, '{3,-1,1,1,1,1,3},
             '{3,2,2,2,1,1,3}};
    return for_kd ? kd_t[i][j] : kp_t[i][j];
  endfunction

  // Updates the tracked gains and returns the drive they produce.
  function automatic out_item_t gain_update(input in_item_t it);
    longint    e, c, acc_p, acc_d, prod, t, drv;
    int        ei[2], ci[2];
    longint    ew[2], cw[2];
    int        en, cn;
    out_item_t res;
    e = longint'(it.error_value);
    c = longint'(it.error_change);
    fuzz(e, err_sp, ei, ew, en);
    fuzz(c, chg_sp, ci, cw, cn);
    acc_p = 0;
    acc_d = 0;
    for (int a = 0; a < en; a++)
      for (int b = 0; b < cn; b++) begin
        prod = (ew[a] * cw[b]) >>> 16;
        acc_p += rule_of(1'b0, ei[a], ci[b]) * prod;
        acc_d += rule_of(1'b1, ei[a], ci[b]) * prod;
      end
    kp_now = clamp(longint'(kp_now) + ((acc_p * LevelStep) >>> 16), p_min, p_max);
    kd_now = clamp(longint'(kd_now) + ((acc_d * LevelStep) >>> 16), d_min, d_max);
    t = e * longint'(kp_now) + c * longint'(kd_now);
    drv = t / One;
    if (drv > DriveLim) drv = DriveLim;
    if (drv < -DriveLim) drv = -DriveLim;
    res.drive      = drv[DrvW-1:0];
    res.p_gain_now = kp_now;
    res.d_gain_now = kd_now;
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", out_cnt, what, got, want);
    fails_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      err_sp  <= 8'd30;   chg_sp  <= 8'd4;
      p_min   <= 65536;   p_max   <= 131072;
      d_min   <= 65536;   d_max   <= 655360;
      p_start <= 78643;   d_start <= 65536;
      kp_now  = 78643;    kd_now  = 65536;
      expected_q.delete();
      in_cnt  <= 0;
      out_cnt <= 0;
      fails_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("MISMATCH output transfer with no prediction waiting");
          fails_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.data.drive !== want.drive)
            report("drive", longint'(out_mon.data.drive), longint'(want.drive));
          if (out_mon.data.p_gain_now !== want.p_gain_now)
            report("p_gain_now", out_mon.data.p_gain_now, want.p_gain_now);
          if (out_mon.data.d_gain_now !== want.d_gain_now)
            report("d_gain_now", out_mon.data.d_gain_now, want.d_gain_now);
        end
        out_cnt <= out_cnt + 1;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(gain_update(in_mon.data));
        in_cnt <= in_cnt + 1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegErrSp:  err_sp  <= cfg_data_i[SpW-1:0];
          RegChgSp:  chg_sp  <= cfg_data_i[SpW-1:0];
          RegPMin:   p_min   <= cfg_data_i;
          RegPMax:   p_max   <= cfg_data_i;
          RegDMin:   d_min   <= cfg_data_i;
          RegDMax:   d_max   <= cfg_data_i;
          RegPStart: p_start <= cfg_data_i;
          RegDStart: d_start <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the fuzzy gain-scheduled PD controller through several register
// settings and idling patterns, with a checker alongside predicting results.
// ----------------------------------------------------------------------------
module testbench;
  import fgpd_pkg::*;

  localparam int WatchLimit = 5000;
  localparam int RandPerPhase = 215;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [GainW-1:0]    cfg_data;
  int                  fails, pending, checked;
  int                  idle_pct, stall_pct;
  int                  quiet_cycles;
  int                  settings_done;

  fgpd_if #(.T(in_item_t))  in_ch ();
  fgpd_if #(.T(out_item_t)) out_ch ();

  fuzzy_gain_scheduled_pd uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fgpd_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fails_o    (fails),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Timeout: no transfer for %0d cycles", WatchLimit);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // One register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic write_all(input logic [SpW-1:0] esp, input logic [SpW-1:0] csp,
                           input logic [GainW-1:0] pmn, input logic [GainW-1:0] pmx,
                           input logic [GainW-1:0] dmn, input logic [GainW-1:0] dmx);
    write_reg(RegErrSp, GainW'(esp));
    write_reg(RegChgSp, GainW'(csp));
    write_reg(RegPMin, pmn);
    write_reg(RegPMax, pmx);
    write_reg(RegDMin, dmn);
    write_reg(RegDMax, dmx);
    // The start values are never loaded into the gains, but they must still accept writes.
    write_reg(RegPStart, GainW'($urandom()));
    write_reg(RegDStart, GainW'($urandom()));
  endtask

  // Offers one item and holds it until the transfer happens. Ready is looked
  // at on the falling edge, where it is settled, so the following rising edge
  // is the transfer. Valid stays high into the next item unless a gap is drawn.
  task automatic send(input int ev, input int ec);
    in_ch.valid             <= 1'b1;
    in_ch.data.error_value  <= ev[ValW-1:0];
    in_ch.data.error_change <= ec[ValW-1:0];
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Mostly values around the membership levels, sometimes the full range.
  function automatic int pick_value(input int sp);
    int v;
    if (sp == 0) sp = 1;
    if ($urandom_range(0, 9) < 7) v = $urandom_range(0, 8 * sp) - 4 * sp;
    else v = int'($urandom_range(0, 4095)) - 2048;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    int esp, csp;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    settings_done = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: range extremes, exact levels, level ends.
    send(-2048, -2048);  send(2047, 2047);  send(-2048, 2047);  send(2047, -2048);
    send(0, 0);          send(-90, -12);    send(90, 12);       send(-91, 13);
    send(30, -4);        send(15, 2);       send(-45, 6);       send(59, -7);
    send(1, -1);         send(-1, 1);       send(2047, 0);      send(0, -2048);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Zero spacing is treated as one; minimum above maximum yields the maximum;
    // the full d gain drives the output into saturation.
    write_all(8'd0, 8'd0, 20'hFFFFF, 20'd1000, 20'hFFFFF, 20'hFFFFF);
    send(2047, 2047);  send(-2048, -2048);  send(0, 1);  send(-1, 0);
    send(2, -2);       send(2047, -2048);
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case (ph)
        0: begin esp = 30;  csp = 4;
          write_all(8'd30, 8'd4, 20'd65536, 20'd131072, 20'd65536, 20'd655360); end
        1: begin esp = 1;   csp = 1;
          write_all(8'd1, 8'd1, 20'd0, 20'hFFFFF, 20'd0, 20'hFFFFF); end
        2: begin esp = 255; csp = 255;
          write_all(8'd255, 8'd255, 20'd1000, 20'd300000, 20'd0, 20'd200000); end
        3: begin esp = 0;   csp = 0;
          write_all(8'd0, 8'd0, 20'd500000, 20'd100000, 20'd0, 20'd0); end
        4: begin esp = $urandom_range(1, 255); csp = $urandom_range(1, 255);
          write_all(SpW'(esp), SpW'(csp), 20'd900000, 20'hFFFFF, 20'd900000, 20'hFFFFF);
        end
        5: begin esp = $urandom_range(1, 40);  csp = $urandom_range(1, 40);
          write_all(SpW'(esp), SpW'(csp), 20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF); end
        6: begin esp = $urandom_range(1, 255); csp = $urandom_range(1, 255);
          write_all(SpW'(esp), SpW'(csp),
                    GainW'($urandom_range(0, 200000)),
                    GainW'($urandom_range(100000, 1048575)),
                    GainW'($urandom_range(0, 200000)),
                    GainW'($urandom_range(100000, 1048575))); end
        default: begin esp = 2; csp = 128;
          write_all(8'd2, 8'd128, 20'd0, 20'd400000, 20'd50000, 20'd800000); end
      endcase
      for (int k = 0; k < RandPerPhase; k++) send(pick_value(esp), pick_value(csp));
      in_ch.valid <= 1'b0;
      settings_done++;
      wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    $display("Covered %0d results over %0d register settings plus directed cases,",
             checked, settings_done);
    $display("with free-running, sender-idle, receiver-stall and mixed phases.");
    if (fails == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, pending);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
